>>> rtl/fpm_pkg.sv
// ============================================================================
// fpm_pkg
// Shared types and constants for the page-mapped flash translation block.
// ============================================================================
package fpm_pkg;

    // parameter defaults
    localparam int DEF_NUM_LOGICAL = 64;
    localparam int DEF_NUM_PAGES   = 128;
    localparam int DEF_BLK_PAGES   = 4;

    // fixed field widths
    localparam int LB_W     = 6;
    localparam int CMD_W    = 3;
    localparam int PAGE_W   = 7;
    localparam int EBLK_W   = 5;
    localparam int TARGET_W = 4;
    localparam int TALLY_W  = 16;
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 24;

    localparam logic [TARGET_W-1:0] TARGET_CAP   = 4'd12;
    localparam logic [TARGET_W-1:0] TARGET_RESET = 4'd12;

    // result command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_READ    = 3'd0,
        CMD_PROGRAM = 3'd1,
        CMD_COPY    = 3'd2,
        CMD_ERASE   = 3'd3,
        CMD_FAIL    = 3'd4,
        CMD_NOSPACE = 3'd5
    } cmd_code_t;

    // page state codes
    typedef enum logic [1:0] {
        PG_FREE  = 2'd0,
        PG_VALID = 2'd1,
        PG_STALE = 2'd2
    } pg_state_t;

    // datapath operations
    typedef enum logic [3:0] {
        DP_NOP,
        DP_LATCH,
        DP_ST_RD,
        DP_MARK,
        DP_SCAN_INIT,
        DP_SCAN,
        DP_PROGRAM,
        DP_UNMAP,
        DP_VICTIM,
        DP_SRC_RD,
        DP_OWN_MAP_RD,
        DP_COPY_WR,
        DP_SRC_STALE,
        DP_K_NEXT,
        DP_ERASE_INIT,
        DP_ERASE_WR
    } dp_op_t;

    typedef struct packed {
        dp_op_t    op;
        logic      emit;
        cmd_code_t kind;
        logic      last;
    } dp_cmd_t;

    typedef struct packed {
        logic oob;
        logic is_write;
        logic mapped;
        logic st_valid;
        logic scan_done;
        logic pick_found;
        logic dest_found;
        logic gc_stop;
        logic k_last;
        logic out_free;
    } dp_stat_t;

endpackage

>>> rtl/fpm_datapath.sv
// ============================================================================
// fpm_datapath
// Map, page state, owner and tally storage, page scan unit, result register.
// ============================================================================
module fpm_datapath
    import fpm_pkg::*;
#(
    parameter int NUM_LOGICAL = DEF_NUM_LOGICAL,
    parameter int NUM_PAGES   = DEF_NUM_PAGES,
    parameter int BLK_PAGES   = DEF_BLK_PAGES
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_op,
    input  logic [LB_W-1:0]     in_lb,
    input  logic                cfg_wr_en,
    input  logic [TARGET_W-1:0] cfg_wr_data,
    input  dp_cmd_t             cmd,
    output dp_stat_t            stat,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [M_DATA_W-1:0] m_data,
    output logic                m_last
);

    localparam int BLK_COUNT = NUM_PAGES / BLK_PAGES;
    localparam int PW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int LW = (NUM_LOGICAL > 1) ? $clog2(NUM_LOGICAL) : 1;
    localparam int BW = (BLK_COUNT > 1) ? $clog2(BLK_COUNT) : 1;
    localparam int KW = $clog2(BLK_PAGES);
    localparam int CW = $clog2(BLK_PAGES + 1);

    // storage
    logic [PW-1:0]      map_mem [NUM_LOGICAL];
    logic               map_vld_reg [NUM_LOGICAL];
    logic [1:0]         st_mem [NUM_PAGES];
    logic               st_vld_reg [NUM_PAGES];
    logic [LW-1:0]      own_mem [NUM_PAGES];
    logic [TALLY_W-1:0] tally_reg [BLK_COUNT];

    // request and read data
    logic               wr_reg;
    logic [LB_W-1:0]    lb_reg;
    logic [PW-1:0]      map_pg_reg;
    logic               map_hit_reg;
    logic [1:0]         st_q_reg;
    logic               st_qv_reg;
    logic [LW-1:0]      own_q_reg;
    logic [TARGET_W-1:0] target_reg;

    // scan unit
    logic [PW:0]        scan_addr_reg;
    logic [KW-1:0]      scan_pib_reg;
    logic [BW-1:0]      scan_blk_reg;
    logic               rd_vld_reg;
    logic [PW-1:0]      rd_idx_reg;
    logic [KW-1:0]      rd_pib_reg;
    logic [BW-1:0]      rd_blk_reg;
    logic [PW:0]        nfree_reg;
    logic               pick_found_reg;
    logic [PW-1:0]      pick_pg_reg;
    logic [TALLY_W-1:0] pick_tally_reg;
    logic               dest_found_reg;
    logic [PW-1:0]      dest_pg_reg;
    logic [CW-1:0]      blk_cnt_reg;
    logic               cand_found_reg;
    logic [CW-1:0]      cand_most_reg;
    logic [BW-1:0]      cand_victim_reg;

    // collection
    logic [BW-1:0]      victim_reg;
    logic [PW-1:0]      src_reg;
    logic [KW-1:0]      k_reg;

    // output register
    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;
    logic                m_last_reg;

    logic [1:0]          st_rd;
    logic                st_re;
    logic [PW-1:0]       st_raddr;
    logic                st_we;
    logic [PW-1:0]       st_waddr;
    logic [1:0]          st_wdata;
    logic                in_range;
    logic [LW-1:0]       lb_idx;
    logic [TARGET_W-1:0] eff_target;
    logic [CW-1:0]       cnt_next;
    logic                scan_issue;
    logic                out_free;
    logic [PW-1:0]       res_page;
    logic [PW-1:0]       res_src;
    logic [BW-1:0]       res_blk;

    assign st_rd      = st_qv_reg ? st_q_reg : PG_FREE;
    assign in_range   = 32'(in_lb) < NUM_LOGICAL;
    assign lb_idx     = LW'(lb_reg);
    assign eff_target = (target_reg > TARGET_CAP) ? TARGET_CAP : target_reg;
    assign scan_issue = (cmd.op == DP_SCAN) && (32'(scan_addr_reg) < NUM_PAGES);
    assign out_free   = !m_valid_reg || m_ready;
    assign cnt_next   = blk_cnt_reg + CW'(st_rd == PG_STALE);

    // page state port selection
    always_comb begin
        st_re    = 1'b0;
        st_raddr = src_reg;
        st_we    = 1'b0;
        st_waddr = src_reg;
        st_wdata = PG_FREE;
        unique case (cmd.op)
            DP_SCAN: begin
                st_re    = scan_issue;
                st_raddr = scan_addr_reg[PW-1:0];
            end
            DP_ST_RD: begin
                st_re    = 1'b1;
                st_raddr = map_pg_reg;
            end
            DP_SRC_RD: st_re = 1'b1;
            DP_MARK: begin
                st_we    = map_hit_reg;
                st_waddr = map_pg_reg;
                st_wdata = PG_STALE;
            end
            DP_PROGRAM: begin
                st_we    = 1'b1;
                st_waddr = pick_pg_reg;
                st_wdata = PG_VALID;
            end
            DP_COPY_WR: begin
                st_we    = 1'b1;
                st_waddr = dest_pg_reg;
                st_wdata = PG_VALID;
            end
            DP_SRC_STALE: begin
                st_we    = 1'b1;
                st_wdata = PG_STALE;
            end
            DP_ERASE_WR: begin
                st_we    = 1'b1;
                st_wdata = PG_FREE;
            end
            default: ;
        endcase
    end

    // page state memory, valid bits make unwritten pages read free
    always_ff @(posedge aclk) begin
        if (st_we) begin
            st_mem[st_waddr] <= st_wdata;
        end
        if (st_re) begin
            st_q_reg <= st_mem[st_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_PAGES; i++) begin
                st_vld_reg[i] <= 1'b0;
            end
            st_qv_reg <= 1'b0;
        end else begin
            if (st_we) begin
                st_vld_reg[st_waddr] <= 1'b1;
            end
            if (st_re) begin
                st_qv_reg <= st_vld_reg[st_raddr];
            end
        end
    end

    // owner memory
    always_ff @(posedge aclk) begin
        if (cmd.op == DP_PROGRAM) begin
            own_mem[pick_pg_reg] <= lb_idx;
        end else if (cmd.op == DP_COPY_WR) begin
            own_mem[dest_pg_reg] <= own_q_reg;
        end
        if (cmd.op == DP_SRC_RD) begin
            own_q_reg <= own_mem[src_reg];
        end
    end

    // logical map memory
    always_ff @(posedge aclk) begin
        if (cmd.op == DP_PROGRAM) begin
            map_mem[lb_idx] <= pick_pg_reg;
        end else if (cmd.op == DP_COPY_WR && map_hit_reg && map_pg_reg == src_reg) begin
            map_mem[own_q_reg] <= dest_pg_reg;
        end
        if (cmd.op == DP_LATCH && in_range) begin
            map_pg_reg <= map_mem[LW'(in_lb)];
        end else if (cmd.op == DP_OWN_MAP_RD) begin
            map_pg_reg <= map_mem[own_q_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_LOGICAL; i++) begin
                map_vld_reg[i] <= 1'b0;
            end
            map_hit_reg <= 1'b0;
        end else begin
            if (cmd.op == DP_PROGRAM) begin
                map_vld_reg[lb_idx] <= 1'b1;
            end else if (cmd.op == DP_UNMAP) begin
                map_vld_reg[lb_idx] <= 1'b0;
            end
            if (cmd.op == DP_LATCH) begin
                map_hit_reg <= in_range && map_vld_reg[LW'(in_lb)];
            end else if (cmd.op == DP_OWN_MAP_RD) begin
                map_hit_reg <= map_vld_reg[own_q_reg];
            end
        end
    end

    // erase tallies and config
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < BLK_COUNT; i++) begin
                tally_reg[i] <= '0;
            end
            target_reg <= TARGET_RESET;
        end else begin
            if (cmd.op == DP_ERASE_INIT) begin
                tally_reg[victim_reg] <= tally_reg[victim_reg] + TALLY_W'(1);
            end
            if (cfg_wr_en) begin
                target_reg <= cfg_wr_data;
            end
        end
    end

    // request capture, scan unit, collection pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg    <= 1'b0;
            scan_addr_reg <= '0;
        end else begin
            if (cmd.op == DP_LATCH) begin
                wr_reg <= in_op;
                lb_reg <= in_lb;
            end
            if (cmd.op == DP_SCAN_INIT) begin
                scan_addr_reg  <= '0;
                scan_pib_reg   <= '0;
                scan_blk_reg   <= '0;
                rd_vld_reg     <= 1'b0;
                nfree_reg      <= '0;
                pick_found_reg <= 1'b0;
                dest_found_reg <= 1'b0;
                blk_cnt_reg    <= '0;
                cand_found_reg <= 1'b0;
                cand_most_reg  <= '0;
            end else if (cmd.op == DP_SCAN) begin
                rd_vld_reg <= scan_issue;
                rd_idx_reg <= scan_addr_reg[PW-1:0];
                rd_pib_reg <= scan_pib_reg;
                rd_blk_reg <= scan_blk_reg;
                if (scan_issue) begin
                    scan_addr_reg <= scan_addr_reg + 1'b1;
                    if (32'(scan_pib_reg) == BLK_PAGES - 1) begin
                        scan_pib_reg <= '0;
                        scan_blk_reg <= scan_blk_reg + 1'b1;
                    end else begin
                        scan_pib_reg <= scan_pib_reg + 1'b1;
                    end
                end
                if (rd_vld_reg) begin
                    if (st_rd == PG_FREE) begin
                        nfree_reg <= nfree_reg + 1'b1;
                        if (!pick_found_reg || tally_reg[rd_blk_reg] < pick_tally_reg) begin
                            pick_found_reg <= 1'b1;
                            pick_pg_reg    <= rd_idx_reg;
                            pick_tally_reg <= tally_reg[rd_blk_reg];
                        end
                        if (!dest_found_reg && rd_blk_reg != victim_reg) begin
                            dest_found_reg <= 1'b1;
                            dest_pg_reg    <= rd_idx_reg;
                        end
                    end
                    if (32'(rd_pib_reg) == BLK_PAGES - 1) begin
                        blk_cnt_reg <= '0;
                        if (!cand_found_reg || cnt_next > cand_most_reg) begin
                            cand_found_reg  <= 1'b1;
                            cand_most_reg   <= cnt_next;
                            cand_victim_reg <= rd_blk_reg;
                        end
                    end else begin
                        blk_cnt_reg <= cnt_next;
                    end
                end
            end
            unique case (cmd.op)
                DP_VICTIM: begin
                    victim_reg <= cand_victim_reg;
                    src_reg    <= PW'(cand_victim_reg) * PW'(BLK_PAGES);
                    k_reg      <= '0;
                end
                DP_ERASE_INIT: begin
                    src_reg <= PW'(victim_reg) * PW'(BLK_PAGES);
                    k_reg   <= '0;
                end
                DP_K_NEXT, DP_ERASE_WR: begin
                    src_reg <= src_reg + 1'b1;
                    k_reg   <= k_reg + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // result register
    assign res_page = (cmd.kind == CMD_READ)    ? map_pg_reg :
                      (cmd.kind == CMD_PROGRAM) ? pick_pg_reg :
                      (cmd.kind == CMD_COPY)    ? dest_pg_reg : '0;
    assign res_src  = (cmd.kind == CMD_COPY)  ? src_reg : '0;
    assign res_blk  = (cmd.kind == CMD_ERASE) ? victim_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
            m_last_reg  <= cmd.last;
            m_data_reg  <= {2'b00, EBLK_W'(res_blk), PAGE_W'(res_src),
                            PAGE_W'(res_page), cmd.kind};
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign m_last  = m_last_reg;

    assign stat.oob        = 32'(lb_reg) >= NUM_LOGICAL;
    assign stat.is_write   = wr_reg;
    assign stat.mapped     = map_hit_reg;
    assign stat.st_valid   = st_rd == PG_VALID;
    assign stat.scan_done  = (32'(scan_addr_reg) == NUM_PAGES) && !rd_vld_reg;
    assign stat.pick_found = pick_found_reg;
    assign stat.dest_found = dest_found_reg;
    assign stat.gc_stop    = (nfree_reg >= (PW+1)'(eff_target)) || (cand_most_reg == '0);
    assign stat.k_last     = 32'(k_reg) == BLK_PAGES - 1;
    assign stat.out_free   = out_free;

`ifndef ASSERT_OFF
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> out_free) else $error("result loaded over a pending one");
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(scan_addr_reg) <= NUM_PAGES) else $error("scan address overran");
    a_copy_dest: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == DP_COPY_WR |-> dest_found_reg) else $error("copy without free page");
    a_prog_pick: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == DP_PROGRAM |-> pick_found_reg) else $error("program without free page");
`endif

endmodule

>>> rtl/fpm_ctrl.sv
// ============================================================================
// fpm_ctrl
// Request sequencer: lookup, allocation, collection rounds, result issue.
// ============================================================================
module fpm_ctrl
    import fpm_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_DECODE, ST_RD_ST, ST_RD_CHK, ST_MARK,
        ST_PICK_INIT, ST_PICK_SCAN, ST_PROGRAM, ST_UNMAP,
        ST_GC_INIT, ST_GC_SCAN, ST_VICTIM, ST_SRC_RD, ST_SRC_CHK,
        ST_DEST_INIT, ST_DEST_SCAN, ST_EMIT_COPY, ST_OWN_RD, ST_COPY_WR,
        ST_SRC_STALE, ST_NEXT, ST_EMIT_ERASE, ST_ERASE_WR, ST_EMIT_FINAL
    } state_t;

    state_t    state_reg, state_next;
    cmd_code_t final_reg, final_next;
    logic [1:0] gc_cnt_reg, gc_cnt_next;

    assign in_ready = state_reg == ST_IDLE;

    always_comb begin
        state_next  = state_reg;
        final_next  = final_reg;
        gc_cnt_next = gc_cnt_reg;
        cmd.op   = DP_NOP;
        cmd.emit = 1'b0;
        cmd.kind = final_reg;
        cmd.last = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                gc_cnt_next = '0;
                if (in_valid) begin
                    cmd.op     = DP_LATCH;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (stat.oob) begin
                    final_next = stat.is_write ? CMD_NOSPACE : CMD_FAIL;
                    state_next = ST_EMIT_FINAL;
                end else if (!stat.is_write) begin
                    final_next = CMD_FAIL;
                    state_next = stat.mapped ? ST_RD_ST : ST_EMIT_FINAL;
                end else begin
                    state_next = ST_MARK;
                end
            end
            ST_RD_ST: begin
                cmd.op     = DP_ST_RD;
                state_next = ST_RD_CHK;
            end
            ST_RD_CHK: begin
                final_next = stat.st_valid ? CMD_READ : CMD_FAIL;
                state_next = ST_EMIT_FINAL;
            end
            ST_MARK: begin
                cmd.op     = DP_MARK;
                state_next = ST_PICK_INIT;
            end
            ST_PICK_INIT: begin
                cmd.op     = DP_SCAN_INIT;
                state_next = ST_PICK_SCAN;
            end
            ST_PICK_SCAN: begin
                cmd.op = DP_SCAN;
                if (stat.scan_done) begin
                    if (stat.pick_found) begin
                        state_next = ST_PROGRAM;
                    end else if (gc_cnt_reg == 2'd2) begin
                        state_next = ST_UNMAP;
                    end else begin
                        gc_cnt_next = gc_cnt_reg + 2'd1;
                        state_next  = ST_GC_INIT;
                    end
                end
            end
            ST_PROGRAM: begin
                cmd.op     = DP_PROGRAM;
                final_next = CMD_PROGRAM;
                state_next = ST_EMIT_FINAL;
            end
            ST_UNMAP: begin
                cmd.op     = DP_UNMAP;
                final_next = CMD_NOSPACE;
                state_next = ST_EMIT_FINAL;
            end
            ST_GC_INIT: begin
                cmd.op     = DP_SCAN_INIT;
                state_next = ST_GC_SCAN;
            end
            ST_GC_SCAN: begin
                cmd.op = DP_SCAN;
                if (stat.scan_done) begin
                    state_next = stat.gc_stop ? ST_PICK_INIT : ST_VICTIM;
                end
            end
            ST_VICTIM: begin
                cmd.op     = DP_VICTIM;
                state_next = ST_SRC_RD;
            end
            ST_SRC_RD: begin
                cmd.op     = DP_SRC_RD;
                state_next = ST_SRC_CHK;
            end
            ST_SRC_CHK: begin
                state_next = stat.st_valid ? ST_DEST_INIT : ST_NEXT;
            end
            ST_DEST_INIT: begin
                cmd.op     = DP_SCAN_INIT;
                state_next = ST_DEST_SCAN;
            end
            ST_DEST_SCAN: begin
                cmd.op = DP_SCAN;
                if (stat.scan_done) begin
                    // no room outside the victim: round ends, block not erased
                    state_next = stat.dest_found ? ST_EMIT_COPY : ST_PICK_INIT;
                end
            end
            ST_EMIT_COPY: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = CMD_COPY;
                    state_next = ST_OWN_RD;
                end
            end
            ST_OWN_RD: begin
                cmd.op     = DP_OWN_MAP_RD;
                state_next = ST_COPY_WR;
            end
            ST_COPY_WR: begin
                cmd.op     = DP_COPY_WR;
                state_next = ST_SRC_STALE;
            end
            ST_SRC_STALE: begin
                cmd.op     = DP_SRC_STALE;
                state_next = ST_NEXT;
            end
            ST_NEXT: begin
                if (stat.k_last) begin
                    state_next = ST_EMIT_ERASE;
                end else begin
                    cmd.op     = DP_K_NEXT;
                    state_next = ST_SRC_RD;
                end
            end
            ST_EMIT_ERASE: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = CMD_ERASE;
                    cmd.op     = DP_ERASE_INIT;
                    state_next = ST_ERASE_WR;
                end
            end
            ST_ERASE_WR: begin
                cmd.op = DP_ERASE_WR;
                if (stat.k_last) begin
                    state_next = ST_GC_INIT;
                end
            end
            ST_EMIT_FINAL: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            final_reg  <= CMD_FAIL;
            gc_cnt_reg <= '0;
        end else begin
            state_reg  <= state_next;
            final_reg  <= final_next;
            gc_cnt_reg <= gc_cnt_next;
        end
    end

`ifndef ASSERT_OFF
    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && in_valid) |=> state_reg != ST_IDLE)
        else $error("accepted item not started");
    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && cmd.last) |=> state_reg == ST_IDLE)
        else $error("final result did not end request");
    a_gc_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        gc_cnt_reg != 2'd3) else $error("too many collection passes");
`endif

endmodule

>>> rtl/flash_page_map_gc_wear_top.sv
// ============================================================================
// flash_page_map_gc_wear_top
// Page-mapped flash translation with wear-aware allocation and greedy GC.
// ============================================================================
//
//  channel   dir  handshake          payload
//  s_        in   s_tvalid/s_tready  tdata: operation[0], logical_block[6:1]
//  m_        out  m_tvalid/m_tready  tdata: command, page, source_page,
//                                    erase_block; tlast: last
//  cfg_      in   cfg_wr_en          cfg_wr_data: gc_free_target
//
//  One item at a time. A write runs one full page-state scan (one page
//  per cycle through the single state memory read port) per allocation,
//  per collection round check and per copy destination search.
//  Reset is synchronous; maps, page states and tallies clear at once via
//  valid bits and reset flops, no clearing pass. A stalled m_ channel holds
//  the sequencer at its next result; s_tready is high only when idle.
//
module flash_page_map_gc_wear_top
    import fpm_pkg::*;
#(
    parameter int NUM_LOGICAL = DEF_NUM_LOGICAL,
    parameter int NUM_PAGES   = DEF_NUM_PAGES,
    parameter int BLK_PAGES   = DEF_BLK_PAGES
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,     // operation[0], logical_block[6:1]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,     // command[2:0], page[9:3],
                                             // source_page[16:10], erase_block[21:17]
    output logic                m_tlast,
    input  logic                cfg_wr_en,
    input  logic [TARGET_W-1:0] cfg_wr_data  // gc_free_target
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    fpm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    fpm_datapath #(
        .NUM_LOGICAL (NUM_LOGICAL),
        .NUM_PAGES   (NUM_PAGES),
        .BLK_PAGES   (BLK_PAGES)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_op       (s_tdata[0]),
        .in_lb       (s_tdata[LB_W:1]),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .stat        (stat),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .m_data      (m_tdata),
        .m_last      (m_tlast)
    );

endmodule
